// ----- rtl/pmid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pmid_pkg;

    localparam int COORD_W  = 24;            // signed Q11.12 coordinate
    localparam int BOX_W    = 23;            // unsigned Q11.12 box length
    localparam int DELTA_W  = COORD_W + 1;   // first minus second
    localparam int IMAGE_W  = COORD_W + 2;   // delta plus or minus a box length
    localparam int PROD_W   = 2 * IMAGE_W;   // full signed product
    localparam int SQ_W     = PROD_W - 2;    // a square stays below 2^50
    localparam int SUM_W    = SQ_W + 2;      // three squares stay below 3*2^50
    localparam int ROOT_W   = SUM_W / 2;     // result bits, one per cell
    localparam int REM_W    = ROOT_W + 1;    // remainder never exceeds 2*root
    localparam int TRY_W    = REM_W + 2;     // remainder with two radicand bits
    localparam int CFG_IDX_W = 2;

    localparam int FRONT_STAGES = 6;
    localparam int PIPE_LAT     = FRONT_STAGES + ROOT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 2'd1;

    // Data that walks down the square root chain, registered in each cell
    typedef struct packed {
        logic              valid;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SUM_W-1:0]  rad;
    } t_cell_bus;

endpackage

`default_nettype wire

// ----- rtl/pmid_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pmid_front
    import pmid_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic signed [COORD_W-1:0] i_first_x,
    input  wire logic signed [COORD_W-1:0] i_first_y,
    input  wire logic signed [COORD_W-1:0] i_first_z,
    input  wire logic signed [COORD_W-1:0] i_second_x,
    input  wire logic signed [COORD_W-1:0] i_second_y,
    input  wire logic signed [COORD_W-1:0] i_second_z,
    input  wire logic        [BOX_W-1:0]   i_box_x,
    input  wire logic        [BOX_W-1:0]   i_box_y,
    output t_cell_bus                      o_bus
);

    logic [FRONT_STAGES-1:0] r_vld;

    logic signed [DELTA_W-1:0] r_dx, r_dy, r_dz;
    logic signed [IMAGE_W-1:0] r_xs [3];
    logic signed [IMAGE_W-1:0] r_ys [3];
    logic signed [IMAGE_W-1:0] r_zs;
    logic        [SQ_W-1:0]    r_sx [3];
    logic        [SQ_W-1:0]    r_sy [3];
    logic        [SQ_W-1:0]    r_sz2, r_sz3, r_sz4;
    logic        [SQ_W-1:0]    r_mx_ab, r_mx_c, r_my_ab, r_my_c;
    logic        [SQ_W-1:0]    r_mx, r_my;
    logic        [SUM_W-1:0]   r_sum;

    logic signed [IMAGE_W-1:0] lx, ly, dx_ext, dy_ext;
    logic signed [PROD_W-1:0]  px [3];
    logic signed [PROD_W-1:0]  py [3];
    logic signed [PROD_W-1:0]  pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_accept};
        end
    end

    assign lx     = signed'({{(IMAGE_W-BOX_W){1'b0}}, i_box_x});
    assign ly     = signed'({{(IMAGE_W-BOX_W){1'b0}}, i_box_y});
    assign dx_ext = IMAGE_W'(r_dx);
    assign dy_ext = IMAGE_W'(r_dy);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            px[k] = r_xs[k] * r_xs[k];
            py[k] = r_ys[k] * r_ys[k];
        end
        pz = r_zs * r_zs;
    end

    always_ff @(posedge i_clk) begin
        // per-axis separation
        r_dx <= DELTA_W'(i_first_x) - DELTA_W'(i_second_x);
        r_dy <= DELTA_W'(i_first_y) - DELTA_W'(i_second_y);
        r_dz <= DELTA_W'(i_first_z) - DELTA_W'(i_second_z);
        // images: unshifted, minus box, plus box
        r_xs[0] <= dx_ext;
        r_xs[1] <= dx_ext - lx;
        r_xs[2] <= dx_ext + lx;
        r_ys[0] <= dy_ext;
        r_ys[1] <= dy_ext - ly;
        r_ys[2] <= dy_ext + ly;
        r_zs    <= IMAGE_W'(r_dz);
        // squares are never negative, drop the sign bits
        for (int k = 0; k < 3; k++) begin
            r_sx[k] <= px[k][SQ_W-1:0];
            r_sy[k] <= py[k][SQ_W-1:0];
        end
        r_sz2 <= pz[SQ_W-1:0];
        // x and y minimize independently of each other
        r_mx_ab <= (r_sx[1] < r_sx[0]) ? r_sx[1] : r_sx[0];
        r_mx_c  <= r_sx[2];
        r_my_ab <= (r_sy[1] < r_sy[0]) ? r_sy[1] : r_sy[0];
        r_my_c  <= r_sy[2];
        r_sz3   <= r_sz2;
        r_mx    <= (r_mx_c < r_mx_ab) ? r_mx_c : r_mx_ab;
        r_my    <= (r_my_c < r_my_ab) ? r_my_c : r_my_ab;
        r_sz4   <= r_sz3;
        r_sum   <= SUM_W'(r_mx) + SUM_W'(r_my) + SUM_W'(r_sz4);
    end

    always_comb begin
        o_bus.valid = r_vld[FRONT_STAGES-1];
        o_bus.rem   = '0;
        o_bus.root  = '0;
        o_bus.rad   = r_sum;
    end

endmodule

`default_nettype wire

// ----- rtl/pmid_sqrt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pmid_sqrt_cell
    import pmid_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_bus i_bus,
    output t_cell_bus      o_bus
);

    logic [TRY_W-1:0] rem_ext, trial, diff;
    logic             fits;
    t_cell_bus        r_bus;

    // bring in the next two radicand bits and try the next root bit
    assign rem_ext = {i_bus.rem, i_bus.rad[SUM_W-1 -: 2]};
    assign trial   = {1'b0, i_bus.root, 2'b01};
    assign fits    = rem_ext >= trial;
    assign diff    = rem_ext - trial;

    // only the valid bit is reset; the data fields follow it down the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= i_bus.valid;
        end
        r_bus.rem  <= fits ? diff[REM_W-1:0] : rem_ext[REM_W-1:0];
        r_bus.root <= {i_bus.root[ROOT_W-2:0], fits};
        r_bus.rad  <= {i_bus.rad[SUM_W-3:0], 2'b00};
    end

    assign o_bus = r_bus;

endmodule

`default_nettype wire

// ----- rtl/periodic_xy_min_image_distance.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                               Transfer
// command   in         start, busy, i_first_*, i_second_*  start high, busy low
// result    out        o_done, o_min_distance              o_done high, one cycle
// config    in         i_cfg_we, i_cfg_idx, i_cfg_data     i_cfg_we high
//
// One transaction is accepted every cycle; busy is always low.
// Each result passes six front stages
// (difference, image shift, square, two min steps, sum) and a chain of
// 26 square root cells, one root bit per cell.
// Reset is synchronous and clears the box lengths and all valid bits.
// The receiver cannot stall; results are never held back.

module periodic_xy_min_image_distance
    import pmid_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [COORD_W-1:0] i_first_x,
    input  wire logic signed [COORD_W-1:0] i_first_y,
    input  wire logic signed [COORD_W-1:0] i_first_z,
    input  wire logic signed [COORD_W-1:0] i_second_x,
    input  wire logic signed [COORD_W-1:0] i_second_y,
    input  wire logic signed [COORD_W-1:0] i_second_z,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [BOX_W-1:0]          i_cfg_data,
    output logic                           o_done,
    output logic [ROOT_W-1:0]              o_min_distance
);

    logic [BOX_W-1:0] r_box_x, r_box_y;
    logic             accept;
    t_cell_bus        chain [ROOT_W+1];

    // Fully pipelined: never hold off a command
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Box lengths; ignore writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x <= '0;
            r_box_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOX_X: r_box_x <= i_cfg_data;
                CFG_BOX_Y: r_box_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: nine images reduced to one minimum squared distance
    pmid_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_first_z  (i_first_z),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_second_z (i_second_z),
        .i_box_x    (r_box_x),
        .i_box_y    (r_box_y),
        .o_bus      (chain[0])
    );

    // Square root chain: each cell settles one root bit, MSB first
    for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
        pmid_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (chain[g]),
            .o_bus   (chain[g+1])
        );
    end

    // The last cell register drives the result ports directly
    assign o_done         = chain[ROOT_W].valid;
    assign o_min_distance = chain[ROOT_W].root;

endmodule

`default_nettype wire

// ----- rtl/pmid_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pmid_checker
    import pmid_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic signed [COORD_W-1:0] i_first_x,
    input wire logic signed [COORD_W-1:0] i_first_y,
    input wire logic signed [COORD_W-1:0] i_first_z,
    input wire logic signed [COORD_W-1:0] i_second_x,
    input wire logic signed [COORD_W-1:0] i_second_y,
    input wire logic signed [COORD_W-1:0] i_second_z,
    input wire logic                      o_done,
    input wire logic [ROOT_W-1:0]         o_min_distance
);

    logic same_pos;
    assign same_pos = (i_first_x == i_second_x) && (i_first_y == i_second_y)
                   && (i_first_z == i_second_z);

    // never stall the command side
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy asserted");

    // every accepted transaction yields a result on o_done
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_done)
        else $error("result missing");

    // no result without an accepted transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, PIPE_LAT))
        else $error("unexpected result");

    // coincident atoms give zero distance through the unshifted image
    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(same_pos, PIPE_LAT)) |-> (o_min_distance == '0))
        else $error("nonzero distance for coincident atoms");

endmodule

bind periodic_xy_min_image_distance pmid_checker u_pmid_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_first_x      (i_first_x),
    .i_first_y      (i_first_y),
    .i_first_z      (i_first_z),
    .i_second_x     (i_second_x),
    .i_second_y     (i_second_y),
    .i_second_z     (i_second_z),
    .o_done         (o_done),
    .o_min_distance (o_min_distance)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import pmid_pkg::*;

    localparam logic [COORD_W-1:0] COORD_MAX = 24'h7F_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 24'h80_0000;
    localparam logic [BOX_W-1:0]   BOX_MAX   = 23'h7F_FFFF;
    localparam int                 Q_ONE     = 4096;     // 1.0 in Q11.12

    // Register indexes that select nothing; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int STALL_LIMIT   = 2000;   // cycles without any transaction
    localparam int PHASES        = 9;
    localparam int PAIRS_PER_PH  = 150;

    typedef enum logic [1:0] {
        OP_PAIR,        // one atom pair on the command port
        OP_BOX_WRITE,   // one register write
        OP_DRAIN        // hold until every pending distance has come back
    } t_op_kind;

    typedef struct {
        t_op_kind             kind;
        int unsigned          gap;
        logic [CFG_IDX_W-1:0] idx;
        logic [BOX_W-1:0]     data;
        logic [COORD_W-1:0]   fx, fy, fz;
        logic [COORD_W-1:0]   sx, sy, sz;
    } t_stim_op;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic [COORD_W-1:0]   i_first_x  = '0;
    logic [COORD_W-1:0]   i_first_y  = '0;
    logic [COORD_W-1:0]   i_first_z  = '0;
    logic [COORD_W-1:0]   i_second_x = '0;
    logic [COORD_W-1:0]   i_second_y = '0;
    logic [COORD_W-1:0]   i_second_z = '0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [BOX_W-1:0]     i_cfg_data = '0;
    logic                 busy;
    logic                 o_done;
    logic [ROOT_W-1:0]    o_min_distance;

    initial forever #1 i_clk = ~i_clk;

    periodic_xy_min_image_distance uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_first_x      (i_first_x),
        .i_first_y      (i_first_y),
        .i_first_z      (i_first_z),
        .i_second_x     (i_second_x),
        .i_second_y     (i_second_y),
        .i_second_z     (i_second_z),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_min_distance (o_min_distance)
    );

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    t_stim_op          stim_ops[$];        // everything the driver still has to issue
    logic [ROOT_W-1:0] dist_expected[$];   // predicted distances, oldest first
    int                n_issued   = 0;     // pairs accepted by the block
    int                n_checked  = 0;     // distances seen on the result port
    int                n_mismatch = 0;
    bit                stim_done  = 1'b0;
    bit                quiet_phase = 1'b0; // no idle gaps while set

    // Our own copy of the box registers, updated when a write lands
    logic [BOX_W-1:0]  box_x_q = '0;
    logic [BOX_W-1:0]  box_y_q = '0;

    task automatic log_mismatch(string what, logic [ROOT_W-1:0] want, logic [ROOT_W-1:0] got);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("mismatch %0d, %s: min_distance expected %0d, got %0d",
                     n_mismatch, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Predictor: smallest of the nine image distances, truncated root
    // ------------------------------------------------------------------
    function automatic logic [ROOT_W-1:0] min_image_dist(t_stim_op p,
                                                          logic [BOX_W-1:0] lx,
                                                          logic [BOX_W-1:0] ly);
        logic signed [63:0] dx, dy, dz, lxs, lys, xi, yj;
        logic [63:0]        zz, s, best, trial;
        logic [ROOT_W-1:0]  root;
        lxs = 64'(lx);
        lys = 64'(ly);
        dx = $signed(p.fx) - $signed(p.sx);
        dy = $signed(p.fy) - $signed(p.sy);
        dz = $signed(p.fz) - $signed(p.sz);
        zz = dz * dz;
        best = '1;
        // z is not periodic, so only x and y get the -L, 0, +L shifts
        for (int i = 0; i < 3; i++) begin
            xi = (i == 0) ? dx : (i == 1) ? dx - lxs : dx + lxs;
            for (int j = 0; j < 3; j++) begin
                yj = (j == 0) ? dy : (j == 1) ? dy - lys : dy + lys;
                s = xi * xi + yj * yj + zz;
                if (s < best) best = s;
            end
        end
        // Bit-by-bit search from the top: keep a bit if its square still fits
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = 64'(root) | (64'd1 << b);
            if (trial * trial <= best) root[b] = 1'b1;
        end
        return root;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly back to back, some short pauses, rarely a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COORD_W-1:0] to_coord(int v);
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        return COORD_W'($urandom);
    endfunction

    function automatic logic [BOX_W-1:0] to_box(int v);
        return v[BOX_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] corner_coord();
        case ($urandom_range(0, 5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return rand_coord();
        endcase
    endfunction

    // A coordinate close to base, or close to base shifted by a full or
    // half box, so that every image gets its turn as the nearest one
    function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] base, int box);
        int span, off;
        span = 1 << $urandom_range(0, 16);
        off  = int'($urandom_range(0, 2 * span)) - span;
        case ($urandom_range(0, 4))
            1:       off += box;
            2:       off -= box;
            3:       off += box / 2;
            4:       off -= box / 2;
            default: ;
        endcase
        return base + off[COORD_W-1:0];
    endfunction

    function automatic logic [BOX_W-1:0] pick_box();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return BOX_MAX;
            2:       return to_box(1);
            3:       return BOX_W'($urandom);
            4:       return to_box(int'($urandom_range(1, 1 << 16)));
            default: return to_box(Q_ONE * int'($urandom_range(1, 100)));
        endcase
    endfunction

    task automatic push_pair(logic [COORD_W-1:0] fx, logic [COORD_W-1:0] fy,
                             logic [COORD_W-1:0] fz, logic [COORD_W-1:0] sx,
                             logic [COORD_W-1:0] sy, logic [COORD_W-1:0] sz);
        t_stim_op op;
        op.kind = OP_PAIR;
        op.gap  = pick_gap();
        op.fx = fx; op.fy = fy; op.fz = fz;
        op.sx = sx; op.sy = sy; op.sz = sz;
        stim_ops.push_back(op);
    endtask

    task automatic push_drain();
        t_stim_op op;
        op.kind = OP_DRAIN;
        op.gap  = 0;
        stim_ops.push_back(op);
    endtask

    // Registers change only once the pipeline has emptied
    task automatic add_box_write(logic [CFG_IDX_W-1:0] idx, logic [BOX_W-1:0] data);
        t_stim_op op;
        push_drain();
        op.kind = OP_BOX_WRITE;
        op.gap  = pick_gap();
        op.idx  = idx;
        op.data = data;
        stim_ops.push_back(op);
    endtask

    task automatic add_random_pair(int lx, int ly);
        logic [COORD_W-1:0] fx, fy, fz;
        int unsigned        mode;
        mode = $urandom_range(0, 9);
        if (mode < 3) begin
            push_pair(rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
        end else if (mode < 5) begin
            push_pair(corner_coord(), corner_coord(), corner_coord(),
                      corner_coord(), corner_coord(), corner_coord());
        end else begin
            fx = rand_coord();
            fy = rand_coord();
            fz = rand_coord();
            push_pair(fx, fy, fz, near_coord(fx, lx), near_coord(fy, ly), near_coord(fz, 0));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence: fill the work list, release reset, wait for the end
    // ------------------------------------------------------------------
    initial begin
        logic [COORD_W-1:0] a, b, c;
        logic [BOX_W-1:0]   lx, ly;

        // Directed part, first with the box lengths at their reset value
        push_pair('0, '0, '0, '0, '0, '0);
        push_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        push_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        push_pair('1, '1, '1, '0, '0, '0);
        a = rand_coord(); b = rand_coord(); c = rand_coord();
        push_pair(a, b, c, a, b, c);

        // Writes to unused indexes must leave both boxes at zero
        add_box_write(CFG_SPARE_2, to_box(Q_ONE));
        add_box_write(CFG_SPARE_3, BOX_MAX);
        push_pair('0, '0, '0, to_coord(Q_ONE), to_coord(Q_ONE), '0);

        // Largest boxes
        add_box_write(CFG_BOX_X, BOX_MAX);
        add_box_write(CFG_BOX_Y, BOX_MAX);
        push_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        push_pair(COORD_MIN, COORD_MIN, '0, COORD_MAX, COORD_MAX, '0);
        push_pair('0, '0, '0, to_coord(int'(BOX_MAX)), to_coord(-int'(BOX_MAX)), '0);

        // Moderate boxes: a shifted image is nearer than the direct one,
        // and a separation of exactly half a box ties two images
        add_box_write(CFG_BOX_X, to_box(10 * Q_ONE));
        add_box_write(CFG_BOX_Y, to_box(7 * Q_ONE));
        push_pair('0, '0, '0, to_coord(10 * Q_ONE - 5), to_coord(-(7 * Q_ONE - 3)), '0);
        push_pair('0, '0, to_coord(Q_ONE), to_coord(5 * Q_ONE), to_coord(-7 * Q_ONE / 2), '0);
        push_pair(rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord());

        // Smallest nonzero box on x only
        add_box_write(CFG_BOX_X, to_box(1));
        add_box_write(CFG_BOX_Y, '0);
        push_pair('0, '0, '0, to_coord(1), '0, '0);
        push_pair('0, '0, '0, to_coord(-1), '0, '0);

        // Random part, one box setting per phase; every third phase has no gaps
        for (int ph = 0; ph < PHASES; ph++) begin
            quiet_phase = (ph % 3 == 1);
            case (ph)
                0:       begin lx = BOX_MAX; ly = BOX_MAX; end
                1:       begin lx = '0;      ly = BOX_MAX; end
                2:       begin lx = BOX_MAX; ly = '0;      end
                default: begin lx = pick_box(); ly = pick_box(); end
            endcase
            add_box_write(CFG_BOX_X, lx);
            add_box_write(CFG_BOX_Y, ly);
            repeat (PAIRS_PER_PH) begin
                if ($urandom_range(0, 99) == 0) push_drain();
                add_random_pair(int'(lx), int'(ly));
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hold until the work list is empty and every pair has answered,
        // then give the pipeline time to show any stray result
        do @(posedge i_clk); while (!(stim_done && n_issued == n_checked));
        repeat (PIPE_LAT + 8) @(posedge i_clk);
        while (dist_expected.size() != 0)
            log_mismatch("never produced", dist_expected.pop_front(), 'x);

        if (n_mismatch == 0)
            $display("PASS periodic_xy_min_image_distance");
        else
            $display("FAIL periodic_xy_min_image_distance");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: one work-list entry at a time, with its idle gap first
    // ------------------------------------------------------------------
    t_stim_op    cur_op;
    t_stim_op    bus_pair;        // the pair currently on the command port
    bit          have_op   = 1'b0;
    int unsigned gap_left  = 0;
    bit          took_pair;
    bit          next_start;
    bit          next_we;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // A write presented last cycle lands at this edge
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BOX_X: box_x_q = i_cfg_data;
                    CFG_BOX_Y: box_y_q = i_cfg_data;
                    default:   ;
                endcase
            end

            // Predict from the box lengths in force when the pair is taken
            took_pair = start && !busy;
            if (took_pair) begin
                dist_expected.push_back(min_image_dist(bus_pair, box_x_q, box_y_q));
                n_issued <= n_issued + 1;
            end

            // Hold an unaccepted transaction; otherwise advance the work list
            next_start = start && !took_pair;
            next_we    = 1'b0;
            if (!next_start) begin
                if (!have_op && stim_ops.size() != 0) begin
                    cur_op   = stim_ops.pop_front();
                    gap_left = cur_op.gap;
                    have_op  = 1'b1;
                end
                if (have_op) begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end else begin
                        case (cur_op.kind)
                            OP_PAIR: begin
                                bus_pair   = cur_op;
                                i_first_x  <= cur_op.fx;
                                i_first_y  <= cur_op.fy;
                                i_first_z  <= cur_op.fz;
                                i_second_x <= cur_op.sx;
                                i_second_y <= cur_op.sy;
                                i_second_z <= cur_op.sz;
                                next_start = 1'b1;
                                have_op    = 1'b0;
                            end
                            OP_BOX_WRITE: begin
                                i_cfg_idx  <= cur_op.idx;
                                i_cfg_data <= cur_op.data;
                                next_we    = 1'b1;
                                have_op    = 1'b0;
                            end
                            OP_DRAIN: begin
                                if (!took_pair && n_issued == n_checked) have_op = 1'b0;
                            end
                            default: have_op = 1'b0;
                        endcase
                    end
                end else if (!took_pair) begin
                    stim_done <= 1'b1;
                end
            end
            start    <= next_start;
            i_cfg_we <= next_we;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each strobed distance against the oldest prediction
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0] dist_want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            n_checked <= n_checked + 1;
            if (dist_expected.size() == 0) begin
                log_mismatch("unexpected result", 'x, o_min_distance);
            end else begin
                dist_want = dist_expected.pop_front();
                if (o_min_distance !== dist_want)
                    log_mismatch("wrong value", dist_want, o_min_distance);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: drop the run if no transaction moves for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAIL periodic_xy_min_image_distance");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ----- files.f -----
rtl/pmid_pkg.sv
rtl/pmid_front.sv
rtl/pmid_sqrt_cell.sv
rtl/periodic_xy_min_image_distance.sv
rtl/pmid_checker.sv
verif/tb_top.sv
